// File: rtl/core/lfu_pkg.sv
// Shared types and constants for the LFU cache engine.
`timescale 1ns / 1ps

package lfu_pkg;

  // Field widths fixed by the request and response formats
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int STAMP_W = 32;
  localparam int CAP_W   = 5;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Value returned by a get that misses
  localparam logic [VALUE_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  // Request kinds carried on in_tuser
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Request sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_UPDATE
  } state_t;

endpackage

// File: rtl/core/lfu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// File: rtl/core/lfu_cache_engine.sv
// Top level of the LFU cache engine: request sequencer, entry scan and update.
//
// Usage:
//   Requests arrive on the in_ channel, one beat per request. in_tuser holds
//   the request kind (0 = get, 1 = put), in_tdata holds key and put value.
//   Every get produces one response beat on the out_ channel: out_tuser is the
//   hit flag, out_tdata the stored value, or all ones on a miss. A put gives
//   no response beat.
//   Each request reads every entry slot once from the entry RAM, one slot per
//   cycle through its single read port, looking for the key, the first free
//   slot and the eviction victim (lowest use count, then oldest use).
//   in_tready is high only while the sequencer is idle. A request steps through
//   the scan state (one read per slot), the tail state that drains the last
//   read, the update state, which can hold, and back to idle before the next accept.
//   A get response is loaded into the output register at the end of the
//   update cycle. The next request may be accepted while a response still
//   waits; if a second get finishes while the receiver stalls, the update
//   cycle holds until the output register frees up.
//   Reset (rst_n low, synchronous) clears all valid bits, the use clock and
//   the output register, and sets capacity to 16. The entry RAM is not
//   cleared. cfg_wr_en writes capacity; write it only while the block idles.
`timescale 1ns / 1ps

module lfu_cache_engine #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] key, [63:32] put_value
  input  logic        in_tuser,   // [0] req_type
  // Response channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_value
  output logic        out_tuser,  // [0] hit
  // Configuration
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int ENT_W = lfu_pkg::KEY_W + lfu_pkg::VALUE_W + COUNT_BITS + lfu_pkg::STAMP_W;

  localparam logic [CNT_W-1:0]      LAST_IDX  = CNT_W'(ENTRIES - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [31:0]           ENTRIES_W = 32'(ENTRIES);

  // Sequencer state
  lfu_pkg::state_t state_r, state_nxt;

  // Request registers
  logic                          req_kind_r;
  logic [lfu_pkg::KEY_W-1:0]     req_key_r;
  logic [lfu_pkg::VALUE_W-1:0]   req_value_r;
  logic [lfu_pkg::STAMP_W-1:0]   stamp_r;
  logic [lfu_pkg::STAMP_W-1:0]   use_clock_r;
  logic [lfu_pkg::CAP_W-1:0]     cap_r;

  // Entry state outside the RAM
  logic [ENTRIES-1:0]            valid_r;

  // Scan control
  logic [CNT_W-1:0]              cnt_r;
  logic                          chk_en_r;
  logic [IDX_W-1:0]              chk_idx_r;

  // Scan results
  logic [CNT_W-1:0]              fill_r;
  logic                          match_found_r;
  logic [IDX_W-1:0]              match_idx_r;
  logic [lfu_pkg::VALUE_W-1:0]   match_value_r;
  logic [COUNT_BITS-1:0]         match_uses_r;
  logic                          free_found_r;
  logic [IDX_W-1:0]              free_idx_r;
  logic                          vic_found_r;
  logic [IDX_W-1:0]              vic_idx_r;
  logic [COUNT_BITS-1:0]         vic_uses_r;
  logic [lfu_pkg::STAMP_W-1:0]   vic_age_r;

  // Output register
  logic                          out_valid_r;
  logic                          out_hit_r;
  logic [lfu_pkg::VALUE_W-1:0]   out_value_r;

  // RAM ports
  logic                          ram_wr_en;
  logic [IDX_W-1:0]              ram_wr_addr;
  logic [ENT_W-1:0]              ram_wr_data;
  logic                          ram_rd_en;
  logic [ENT_W-1:0]              ram_rd_data;

  // Sequencer outputs
  logic                          accept;
  logic                          upd_go;
  logic                          upd_active;
  logic                          scan_last;

  // Fields of the entry under check
  logic [lfu_pkg::KEY_W-1:0]     chk_key;
  logic [lfu_pkg::VALUE_W-1:0]   chk_value;
  logic [COUNT_BITS-1:0]         chk_uses;
  logic [lfu_pkg::STAMP_W-1:0]   chk_last;
  logic [lfu_pkg::STAMP_W-1:0]   chk_age;
  logic                          chk_valid;
  logic                          chk_better;

  // Update decision
  logic [31:0]                   eff_cap;
  logic [31:0]                   fill_ext;
  logic                          cache_full;
  logic [IDX_W-1:0]              ins_slot;
  logic                          ins_ok;
  logic [COUNT_BITS-1:0]         uses_inc;
  logic                          is_get;
  logic                          resp_load;

  lfu_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lfu_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (cnt_r == LAST_IDX) begin
          state_nxt = lfu_pkg::ST_TAIL;
        end
      end
      lfu_pkg::ST_TAIL: begin
        state_nxt = lfu_pkg::ST_UPDATE;
      end
      lfu_pkg::ST_UPDATE: begin
        if (upd_go) begin
          state_nxt = lfu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready  = 1'b0;
    ram_rd_en  = 1'b0;
    upd_active = 1'b0;
    scan_last  = 1'b0;
    case (state_r)
      lfu_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      lfu_pkg::ST_SCAN: begin
        ram_rd_en = 1'b1;
        scan_last = (cnt_r == LAST_IDX);
      end
      lfu_pkg::ST_TAIL: begin
        ram_rd_en = 1'b0;
      end
      lfu_pkg::ST_UPDATE: begin
        upd_active = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign accept = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lfu_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Capture the request and advance the use clock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_clock_r <= '0;
    end else if (accept) begin
      use_clock_r <= use_clock_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind_r  <= in_tuser;
      req_key_r   <= in_tdata[31:0];
      req_value_r <= in_tdata[63:32];
      stamp_r     <= use_clock_r;
    end
  end

  // Advance the read address and tag the returning data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      chk_en_r <= 1'b0;
    end else begin
      chk_en_r <= ram_rd_en;
      if (accept) begin
        cnt_r <= '0;
      end else if (ram_rd_en && !scan_last) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= cnt_r[IDX_W-1:0];
  end

  // Split the entry under check
  assign chk_key   = ram_rd_data[lfu_pkg::KEY_W-1:0];
  assign chk_value = ram_rd_data[lfu_pkg::KEY_W +: lfu_pkg::VALUE_W];
  assign chk_uses  = ram_rd_data[lfu_pkg::KEY_W + lfu_pkg::VALUE_W +: COUNT_BITS];
  assign chk_last  = ram_rd_data[ENT_W-1 -: lfu_pkg::STAMP_W];
  assign chk_valid = valid_r[chk_idx_r];
  assign chk_age   = stamp_r - chk_last;

  // Victim compare: lower count wins, then larger age
  assign chk_better = !vic_found_r || (chk_uses < vic_uses_r) ||
                      ((chk_uses == vic_uses_r) && (chk_age > vic_age_r));

  // Scan flags; cleared on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r        <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      vic_found_r   <= 1'b0;
    end else if (accept) begin
      fill_r        <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      vic_found_r   <= 1'b0;
    end else if (chk_en_r) begin
      if (!chk_valid) begin
        free_found_r <= 1'b1;
      end else begin
        fill_r      <= fill_r + CNT_W'(1);
        vic_found_r <= 1'b1;
        if (chk_key == req_key_r) begin
          match_found_r <= 1'b1;
        end
      end
    end
  end

  // Scan payload: first free slot, first match, best victim
  always_ff @(posedge clk) begin
    if (chk_en_r) begin
      if (!chk_valid) begin
        if (!free_found_r) begin
          free_idx_r <= chk_idx_r;
        end
      end else begin
        if (!match_found_r && (chk_key == req_key_r)) begin
          match_idx_r   <= chk_idx_r;
          match_value_r <= chk_value;
          match_uses_r  <= chk_uses;
        end
        if (chk_better) begin
          vic_idx_r  <= chk_idx_r;
          vic_uses_r <= chk_uses;
          vic_age_r  <= chk_age;
        end
      end
    end
  end

  // Clamp capacity to 1..ENTRIES and pick the insert slot
  always_comb begin
    eff_cap = {{(32 - lfu_pkg::CAP_W){1'b0}}, cap_r};
    if (cap_r == '0) begin
      eff_cap = 32'd1;
    end else if (eff_cap > ENTRIES_W) begin
      eff_cap = ENTRIES_W;
    end
  end

  assign fill_ext   = {{(32 - CNT_W){1'b0}}, fill_r};
  assign cache_full = (fill_ext >= eff_cap) && vic_found_r;
  assign ins_slot   = cache_full ? vic_idx_r : (free_found_r ? free_idx_r : vic_idx_r);
  assign ins_ok     = cache_full || free_found_r || vic_found_r;
  assign uses_inc   = (match_uses_r == COUNT_MAX) ? match_uses_r : match_uses_r + COUNT_ONE;
  assign is_get     = (req_kind_r == lfu_pkg::REQ_GET);

  // Hold the update while a get response cannot be loaded
  assign upd_go    = upd_active && (!is_get || !out_valid_r || out_tready);
  assign resp_load = upd_go && is_get;

  // Entry write-back
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = match_idx_r;
    ram_wr_data = {stamp_r, uses_inc, match_value_r, req_key_r};
    if (upd_go) begin
      if (match_found_r) begin
        ram_wr_en = 1'b1;
        if (!is_get) begin
          ram_wr_data = {stamp_r, uses_inc, req_value_r, req_key_r};
        end
      end else if (!is_get && ins_ok) begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = ins_slot;
        ram_wr_data = {stamp_r, COUNT_ONE, req_value_r, req_key_r};
      end
    end
  end

  // Mark an inserted slot valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (upd_go && !is_get && !match_found_r && ins_ok) begin
      valid_r[ins_slot] <= 1'b1;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_hit_r   <= match_found_r;
      out_value_r <= match_found_r ? match_value_r : lfu_pkg::MISS_VALUE;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = out_value_r;

endmodule

// File: tb/tb_lfu_cache_engine.sv
// Testbench for lfu_cache_engine: directed table, then random gets and puts per capacity.
`timescale 1ns / 1ps

module tb_lfu_cache_engine;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int POOL_N     = 24;
  localparam int PHASES     = 9;
  localparam int PHASE_LEN  = 78;
  localparam int N_ROWS     = 28;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } resp_t;

  typedef enum logic [1:0] {
    ROW_GET,
    ROW_PUT,
    ROW_CAP
  } row_op_t;

  // One directed step; fixed marks a response typed in by hand
  typedef struct packed {
    row_op_t     op;
    logic [31:0] key;
    logic [31:0] data;
    logic        fixed;
    logic        hit;
    logic [31:0] value;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [31:0] key, [63:32] put_value
  logic        in_tuser;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] read_value
  logic        out_tuser;  // [0] hit
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;

  // Hand-typed response that travels with the current beat
  logic        table_fixed;
  resp_t       table_resp;

  // Cache state as the block should hold it
  logic                  slot_used  [ENTRIES];
  logic [31:0]           slot_key   [ENTRIES];
  logic [31:0]           slot_val   [ENTRIES];
  logic [COUNT_BITS-1:0] slot_uses  [ENTRIES];
  logic [31:0]           slot_stamp [ENTRIES];
  logic [31:0]           req_clock;
  logic [4:0]            cap_reg;

  resp_t pending_resp[$];
  int    mismatches;
  logic  bursts_on;

  lfu_cache_engine #(
    .ENTRIES   (ENTRIES),
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    // Keep the log short when everything goes wrong
    if (mismatches < 50) $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  // Raise the use count up to its ceiling and stamp the slot
  function automatic void refresh_slot(input int s, input logic [31:0] stamp);
    if (slot_uses[s] != '1) slot_uses[s] = slot_uses[s] + 1'b1;
    slot_stamp[s] = stamp;
  endfunction

  // Serve one request against the predicted cache; a get yields a response
  function automatic void cache_access(input logic is_put, input logic [31:0] key,
                                       input logic [31:0] val, output logic has_resp,
                                       output logic hit_o, output logic [31:0] val_o);
    logic [31:0]           stamp;
    logic [31:0]           age;
    logic [31:0]           best_age;
    logic [COUNT_BITS-1:0] best_uses;
    int                    match, free_slot, victim, fill, slot, eff_cap;
    stamp     = req_clock;
    req_clock = req_clock + 32'd1;
    match     = -1;
    free_slot = -1;
    victim    = -1;
    fill      = 0;
    best_uses = '0;
    best_age  = '0;
    // Scan for the key, the first free slot and the eviction victim
    for (int i = 0; i < ENTRIES; i++) begin
      if (!slot_used[i]) begin
        if (free_slot < 0) free_slot = i;
      end else begin
        fill++;
        if (match < 0 && slot_key[i] == key) match = i;
        age = stamp - slot_stamp[i];
        if (victim < 0 || slot_uses[i] < best_uses ||
            (slot_uses[i] == best_uses && age > best_age)) begin
          victim    = i;
          best_uses = slot_uses[i];
          best_age  = age;
        end
      end
    end
    has_resp = 1'b0;
    hit_o    = 1'b0;
    val_o    = lfu_pkg::MISS_VALUE;
    eff_cap  = (cap_reg == 0) ? 1 : (int'(cap_reg) > ENTRIES) ? ENTRIES : int'(cap_reg);
    if (!is_put) begin
      has_resp = 1'b1;
      if (match >= 0) begin
        hit_o = 1'b1;
        val_o = slot_val[match];
        refresh_slot(match, stamp);
      end
    end else if (match >= 0) begin
      slot_val[match] = val;
      refresh_slot(match, stamp);
    end else begin
      // Insert: evict when full, else take the lowest free slot
      if (fill >= eff_cap && victim >= 0) slot = victim;
      else if (free_slot >= 0) slot = free_slot;
      else slot = victim;
      if (slot >= 0) begin
        slot_used[slot]  = 1'b1;
        slot_key[slot]   = key;
        slot_val[slot]   = val;
        slot_uses[slot]  = COUNT_BITS'(1);
        slot_stamp[slot] = stamp;
      end
    end
  endfunction

  // Track accepted beats and check responses at the rising edge
  always @(posedge clk) begin
    resp_t       want;
    logic        pred_resp;
    logic        pred_hit;
    logic [31:0] pred_val;
    if (rst_n) begin
      if (cfg_wr_en) cap_reg = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (pending_resp.size() == 0) begin
          report_mismatch($sformatf("response with none pending: hit=%0b value=%h",
                                    out_tuser, out_tdata));
        end else begin
          want = pending_resp.pop_front();
          if (out_tuser !== want.hit)
            report_mismatch($sformatf("hit: got %b, want %b", out_tuser, want.hit));
          if (out_tdata !== want.value)
            report_mismatch($sformatf("read_value: got %h, want %h", out_tdata, want.value));
        end
      end
      if (in_tvalid && in_tready) begin
        cache_access(in_tuser, in_tdata[31:0], in_tdata[63:32], pred_resp, pred_hit, pred_val);
        if (pred_resp) begin
          if (table_fixed) begin
            pending_resp.insert(pending_resp.size(), table_resp);
          end else begin
            want.hit   = pred_hit;
            want.value = pred_val;
            pending_resp.insert(pending_resp.size(), want);
          end
        end
      end
    end
  end

  // Receiver: stall in random bursts while bursts are enabled
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (bursts_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Present one request beat and hold it until accepted; valid stays up after
  task automatic send_beat(input logic kind, input logic [31:0] key, input logic [31:0] val,
                           input logic fixed, input logic hit, input logic [31:0] rd_val);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid        <= 1'b1;
    in_tuser         <= kind;
    in_tdata         <= {val, key};
    table_fixed      <= fixed;
    table_resp.hit   <= hit;
    table_resp.value <= rd_val;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop valid, wait for every response, then let the last put finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_resp.size() != 0) @(negedge clk);
    repeat (ENTRIES + 8) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    cfg_wr_data <= cap;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Give up if the run hangs
  initial begin
    #20000000;
    $display("lfu_cache_engine: mismatch");
    $finish;
  end

  initial begin
    row_t        script    [N_ROWS];
    logic [31:0] key_pool  [POOL_N];
    logic [4:0]  phase_cap [PHASES];
    logic [31:0] k;
    int          pool_n;
    int          pick;

    // Directed rows: empty-cache misses, extremes, in-place update, eviction,
    // LRU tiebreak, capacity zero, saturating capacity, capacity below fill
    script = '{
      '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, lfu_pkg::MISS_VALUE},
      '{ROW_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, lfu_pkg::MISS_VALUE},
      '{ROW_PUT, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{ROW_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{ROW_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      '{ROW_GET, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, lfu_pkg::MISS_VALUE},
      '{ROW_PUT, 32'h0000_0002, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0002, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{ROW_CAP, 32'h0000_0000, 32'd3,         1'b0, 1'b0, 32'h0},
      '{ROW_PUT, 32'h0000_0003, 32'h0000_0033, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CAP, 32'h0000_0000, 32'd0,         1'b0, 1'b0, 32'h0},
      '{ROW_PUT, 32'h0000_0004, 32'h0000_0044, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0003, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0004, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CAP, 32'h0000_0000, 32'd31,        1'b0, 1'b0, 32'h0},
      '{ROW_PUT, 32'h0000_0005, 32'h0000_0055, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_PUT, 32'h0000_0004, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0004, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CAP, 32'h0000_0000, 32'd1,         1'b0, 1'b0, 32'h0},
      '{ROW_PUT, 32'h0000_0006, 32'h0000_0066, 1'b0, 1'b0, 32'h0},
      '{ROW_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
    };

    // Quiet inputs and predicted state at time zero
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = lfu_pkg::REQ_GET;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    table_fixed = 1'b0;
    table_resp  = '0;
    bursts_on   = 1'b1;
    mismatches  = 0;
    req_clock   = '0;
    cap_reg     = lfu_pkg::CAP_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_used[i]  = 1'b0;
      slot_key[i]   = '0;
      slot_val[i]   = '0;
      slot_uses[i]  = '0;
      slot_stamp[i] = '0;
    end

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom;
    phase_cap = '{5'd16, 5'd1, 5'd2, 5'd5, 5'd31, 5'd0, 5'd17, 5'd8, 5'd0};
    phase_cap[PHASES-1] = 5'($urandom_range(0, 31));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    for (int r = 0; r < N_ROWS; r++) begin
      if (script[r].op == ROW_CAP) begin
        settle();
        write_capacity(script[r].data[4:0]);
      end else begin
        send_beat(script[r].op == ROW_PUT ? lfu_pkg::REQ_PUT : lfu_pkg::REQ_GET,
                  script[r].key, script[r].data, script[r].fixed, script[r].hit,
                  script[r].value);
      end
    end

    // Random phases, one capacity each; the last two run without bursts
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_capacity(phase_cap[p]);
      if (p >= PHASES - 2) bursts_on = 1'b0;
      pool_n = $urandom_range(2, POOL_N);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 59) == 0) settle();
        pick = $urandom_range(0, 99);
        if (pick < 85) k = key_pool[$urandom_range(0, pool_n - 1)];
        else if (pick < 95) k = key_pool[$urandom_range(0, POOL_N - 1)];
        else k = $urandom;
        send_beat($urandom_range(0, 1) ? lfu_pkg::REQ_PUT : lfu_pkg::REQ_GET, k, $urandom,
                  1'b0, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("lfu_cache_engine: match");
    end else begin
      $display("lfu_cache_engine: mismatch");
    end
    $finish;
  end

endmodule
